FILE: hw/rtl/mbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_pkg: shared definitions for the 2x2 box mip downsampler
// Sizes, register indexes and the request type carried from front to back.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int LINE_DEPTH   = MAX_WIDTH / 2;

  localparam int SIZE_W  = 13;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
  localparam int IDX_W   = $clog2(LINE_DEPTH);
  localparam int CHAN_W  = 8;
  localparam int SUM_W   = CHAN_W + 1;
  localparam int NUM_CH  = 4;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = CFG_INDEX_W'(1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] WIDTH_MAX  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_MAX = SIZE_W'(HEIGHT_LIMIT);

  // One line store request: either store pair sums (even row) or read them
  // back and emit an averaged pixel (odd row).
  typedef struct packed {
    logic                           emit;
    logic [IDX_W-1:0]               idx;
    logic [NUM_CH-1:0][SUM_W-1:0]   sums;
    logic                           last;
  } mbd_req_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < SIZE_MIN) begin
      r = SIZE_MIN;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/mbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_front: pixel intake and classification
// Tracks raster position, pairs even and odd columns into pair sums, and
// issues store or emit requests to the queue. Holds the size registers.
// ----------------------------------------------------------------------------
module mbd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mbd_pkg::CHAN_W-1:0]        red,
  input  logic [mbd_pkg::CHAN_W-1:0]        green,
  input  logic [mbd_pkg::CHAN_W-1:0]        blue,
  input  logic [mbd_pkg::CHAN_W-1:0]        alpha,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mbd_pkg::SIZE_W-1:0]        cfg_data,
  input  logic                              q_full,
  output logic                              push,
  output mbd_pkg::mbd_req_t                 push_req
);

  logic [mbd_pkg::SIZE_W-1:0]                        width;
  logic [mbd_pkg::SIZE_W-1:0]                        height;
  logic [mbd_pkg::COL_W-1:0]                         column_count;
  logic [mbd_pkg::ROW_W-1:0]                         row_count;
  logic [mbd_pkg::NUM_CH-1:0][mbd_pkg::CHAN_W-1:0]   held_pixel;
  logic [mbd_pkg::NUM_CH-1:0][mbd_pkg::CHAN_W-1:0]   pix;
  logic [mbd_pkg::SIZE_W-1:0]                        col_ext;
  logic [mbd_pkg::SIZE_W-1:0]                        row_ext;
  logic                                              accept;
  logic                                              in_block;
  logic                                              col_wrap;
  logic                                              row_wrap;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  assign pix     = {alpha, blue, green, red};
  assign col_ext = mbd_pkg::SIZE_W'(column_count);
  assign row_ext = mbd_pkg::SIZE_W'(row_count);

  // Odd column inside the even-sized area closes a 2x1 pair.
  assign in_block = column_count[0] &&
                    (col_ext < {width[mbd_pkg::SIZE_W-1:1], 1'b0}) &&
                    (row_ext < {height[mbd_pkg::SIZE_W-1:1], 1'b0});

  assign col_wrap = (col_ext + mbd_pkg::SIZE_W'(1)) >= width;
  assign row_wrap = (row_ext + mbd_pkg::SIZE_W'(1)) >= height;

  assign push = accept && in_block;

  always_comb begin
    push_req.emit = row_count[0];
    push_req.idx  = column_count[mbd_pkg::COL_W-1:1];
    for (int ch = 0; ch < mbd_pkg::NUM_CH; ch++) begin
      push_req.sums[ch] = {1'b0, held_pixel[ch]} + {1'b0, pix[ch]};
    end
    push_req.last = ((col_ext >> 1) == ((width >> 1) - mbd_pkg::SIZE_W'(1))) &&
                    ((row_ext >> 1) == ((height >> 1) - mbd_pkg::SIZE_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width        <= mbd_pkg::SIZE_MIN;
      height       <= mbd_pkg::SIZE_MIN;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      // Any write, known index or not, restarts the level.
      if (cfg_index == mbd_pkg::REG_SRC_WIDTH) begin
        width <= mbd_pkg::clamp_size(cfg_data, mbd_pkg::WIDTH_MAX);
      end else if (cfg_index == mbd_pkg::REG_SRC_HEIGHT) begin
        height <= mbd_pkg::clamp_size(cfg_data, mbd_pkg::HEIGHT_MAX);
      end
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_count + mbd_pkg::ROW_W'(1);
      end else begin
        column_count <= column_count + mbd_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !column_count[0]) begin
      held_pixel <= pix;
    end
  end

endmodule

FILE: hw/rtl/mbd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_queue: request queue between front and back
// A small circular buffer so intake and line store work stall independently.
// ----------------------------------------------------------------------------
module mbd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mbd_pkg::mbd_req_t  push_req,
  output logic               q_full,
  input  logic               pop,
  output logic               q_valid,
  output mbd_pkg::mbd_req_t  q_req
);

  mbd_pkg::mbd_req_t              slots [mbd_pkg::QUEUE_DEPTH];
  logic [mbd_pkg::QPTR_W-1:0]     wr_ptr;
  logic [mbd_pkg::QPTR_W-1:0]     rd_ptr;
  logic [mbd_pkg::QCNT_W-1:0]     count;

  assign q_full  = (count == mbd_pkg::QCNT_W'(mbd_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_req   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mbd_pkg::QPTR_W'(mbd_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + mbd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == mbd_pkg::QPTR_W'(mbd_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + mbd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + mbd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - mbd_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

FILE: hw/rtl/mbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_back: line store and averaging
// Unless stalled, runs one line store access per cycle: stores pair sums on
// even rows, reads them on odd rows, then averages into the output register.
// ----------------------------------------------------------------------------
module mbd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  mbd_pkg::mbd_req_t            q_req,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mbd_pkg::CHAN_W-1:0]   out_red,
  output logic [mbd_pkg::CHAN_W-1:0]   out_green,
  output logic [mbd_pkg::CHAN_W-1:0]   out_blue,
  output logic [mbd_pkg::CHAN_W-1:0]   out_alpha,
  output logic                         last_pixel
);

  logic [mbd_pkg::NUM_CH-1:0][mbd_pkg::SUM_W-1:0]  pair_sum_line [mbd_pkg::LINE_DEPTH];
  logic [mbd_pkg::NUM_CH-1:0][mbd_pkg::SUM_W-1:0]  rd_data;
  logic                                            s1_valid;
  mbd_pkg::mbd_req_t                               s1_req;
  logic                                            out_free;
  logic                                            s1_free;
  logic [mbd_pkg::NUM_CH-1:0][mbd_pkg::CHAN_W-1:0] avg;

  assign out_free = !out_valid || !out_stall;
  assign s1_free  = !s1_valid || out_free;
  // Stores retire at the memory; only reads need room in the read stage.
  assign pop      = q_valid && (!q_req.emit || s1_free);

  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_req.emit) begin
        rd_data <= pair_sum_line[q_req.idx];
      end else begin
        pair_sum_line[q_req.idx] <= q_req.sums;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= pop && q_req.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_req.emit) begin
      s1_req <= q_req;
    end
  end

  always_comb begin
    for (int ch = 0; ch < mbd_pkg::NUM_CH; ch++) begin
      logic [mbd_pkg::SUM_W:0] total;
      total   = {1'b0, rd_data[ch]} + {1'b0, s1_req.sums[ch]};
      avg[ch] = total[mbd_pkg::SUM_W:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_red    <= avg[0];
      out_green  <= avg[1];
      out_blue   <= avg[2];
      out_alpha  <= avg[3];
      last_pixel <= s1_req.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_needs_request: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("line store request taken from an empty queue");

  a_read_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid && $stable(rd_data)
      && $stable(s1_req))
    else $error("read stage lost its data while the output was stalled");

  a_output_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("output appeared without a pending line store read");
`endif

endmodule

FILE: hw/rtl/mipmap_box_downsample_rgba.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_box_downsample_rgba: 2x2 box filter mip level generator
// Streams RGBA8 pixels of one level in and the next smaller level out.
// ----------------------------------------------------------------------------
// Usage:
//   Source pixels enter in raster order on red/green/blue/alpha with
//   in_valid; a pixel is taken on a clock edge where in_valid is high and
//   in_stall is low. Each pixel at an odd row and odd column inside the
//   even-sized area produces one averaged pixel on the output channel, taken
//   when out_valid is high and out_stall is low; last_pixel marks the final
//   pixel of the output level. Trailing odd rows and columns produce nothing.
//   Sizes are set through cfg_index/cfg_data with cfg_valid; cfg_ready is
//   always high. Any write restarts the level at row 0, column 0, and writes
//   should only be issued while the block is idle.
//   A result passes through the request queue, the line store and the output
//   register. Throughput: one pixel per clock while in_stall is low, set by
//   the single port line store that does one store or one read each cycle.
//   While the receiver stalls, results back up into a four-entry request
//   queue, and in_stall rises once it is full.
//   Reset clears the position to the top left corner and sets both sizes to 2.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_rgba (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mbd_pkg::CHAN_W-1:0]        red,
  input  logic [mbd_pkg::CHAN_W-1:0]        green,
  input  logic [mbd_pkg::CHAN_W-1:0]        blue,
  input  logic [mbd_pkg::CHAN_W-1:0]        alpha,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mbd_pkg::CHAN_W-1:0]        out_red,
  output logic [mbd_pkg::CHAN_W-1:0]        out_green,
  output logic [mbd_pkg::CHAN_W-1:0]        out_blue,
  output logic [mbd_pkg::CHAN_W-1:0]        out_alpha,
  output logic                              last_pixel,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mbd_pkg::SIZE_W-1:0]        cfg_data
);

  logic               q_full;
  logic               push;
  mbd_pkg::mbd_req_t  push_req;
  logic               pop;
  logic               q_valid;
  mbd_pkg::mbd_req_t  q_req;

  mbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_req  (push_req)
  );

  mbd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .q_full   (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_req    (q_req)
  );

  mbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha),
    .last_pixel (last_pixel)
  );

endmodule

FILE: bench/mipmap_box_downsample_rgba_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_box_downsample_rgba_test: self-checking bench for the 2x2 box mipper
// Streams RGBA8 source levels of many sizes through the block. A scoreboard
// predicts every averaged pixel and its last flag and checks each output
// request in order, while both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [mbd_pkg::CHAN_W-1:0] red;
  logic [mbd_pkg::CHAN_W-1:0] green;
  logic [mbd_pkg::CHAN_W-1:0] blue;
  logic [mbd_pkg::CHAN_W-1:0] alpha;
  logic                       last;
} mip_pixel_t;

typedef logic [mbd_pkg::NUM_CH-1:0][mbd_pkg::CHAN_W-1:0] rgba_t;

class downsample_board;
  logic [mbd_pkg::SIZE_W-1:0]                      width_reg;
  logic [mbd_pkg::SIZE_W-1:0]                      height_reg;
  int unsigned                                     col;
  int unsigned                                     row;
  rgba_t                                           held;
  logic [mbd_pkg::NUM_CH-1:0][mbd_pkg::SUM_W-1:0]  pair_sums [mbd_pkg::LINE_DEPTH];
  mip_pixel_t                                      expected_pixels[$];
  int unsigned                                     errors;

  function new();
    width_reg  = mbd_pkg::SIZE_MIN;
    height_reg = mbd_pkg::SIZE_MIN;
    col        = 0;
    row        = 0;
    held       = '0;
    errors     = 0;
  endfunction

  function int unsigned eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > mbd_pkg::MAX_WIDTH) return mbd_pkg::MAX_WIDTH;
    return width_reg;
  endfunction

  function int unsigned eff_height();
    if (height_reg < 2) return 2;
    if (height_reg > mbd_pkg::HEIGHT_LIMIT) return mbd_pkg::HEIGHT_LIMIT;
    return height_reg;
  endfunction

  function int unsigned level_size();
    return eff_width() * eff_height();
  endfunction

  // Any write, even to an unused index, restarts the level.
  function void write_reg(logic [mbd_pkg::CFG_INDEX_W-1:0] index,
                          logic [mbd_pkg::SIZE_W-1:0] data);
    if (index == mbd_pkg::REG_SRC_WIDTH) begin
      width_reg = data;
    end else if (index == mbd_pkg::REG_SRC_HEIGHT) begin
      height_reg = data;
    end
    col = 0;
    row = 0;
  endfunction

  function void take_source_pixel(rgba_t pix);
    int unsigned                                    w;
    int unsigned                                    h;
    logic [mbd_pkg::NUM_CH-1:0][mbd_pkg::SUM_W-1:0] sums;
    logic [mbd_pkg::SUM_W:0]                        total;
    rgba_t                                          avg;
    mip_pixel_t                                     p;
    w = eff_width();
    h = eff_height();
    if ((col % 2) == 0) begin
      held = pix;
    end else if (col < (w / 2) * 2 && row < (h / 2) * 2) begin
      for (int ch = 0; ch < mbd_pkg::NUM_CH; ch++) begin
        sums[ch] = held[ch] + pix[ch];
      end
      if ((row % 2) == 0) begin
        pair_sums[col / 2] = sums;
      end else begin
        for (int ch = 0; ch < mbd_pkg::NUM_CH; ch++) begin
          total   = pair_sums[col / 2][ch] + sums[ch];
          avg[ch] = total[mbd_pkg::SUM_W:2];
        end
        p.red   = avg[0];
        p.green = avg[1];
        p.blue  = avg[2];
        p.alpha = avg[3];
        p.last  = (col / 2 == w / 2 - 1) && (row / 2 == h / 2 - 1);
        expected_pixels = {expected_pixels, p};
      end
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function void check_output_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic [7:0] a, logic last);
    mip_pixel_t want;
    if (expected_pixels.size() == 0) begin
      errors++;
      $display("%0t: output pixel expected none, got r=%0d g=%0d b=%0d a=%0d last=%0d",
               $time, r, g, b, a, last);
      return;
    end
    want = expected_pixels.pop_front();
    compare_field("out_red", want.red, r);
    compare_field("out_green", want.green, g);
    compare_field("out_blue", want.blue, b);
    compare_field("out_alpha", want.alpha, a);
    compare_field("last_pixel", want.last, last);
  endfunction
endclass

module mipmap_box_downsample_rgba_test;

  localparam logic [mbd_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [mbd_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic [mbd_pkg::SIZE_W-1:0]      SIZE_ALL_ONES = '1;
  localparam logic [mbd_pkg::SIZE_W-1:0]      BIG_SIDE      = 13'd128;
  localparam int    SETTLE_CYCLES = 6;
  localparam int    HOLD_CYCLES   = 300;
  localparam int    RANDOM_ITEMS  = 1260;
  localparam int    BIG_LEVEL     = 256;
  localparam int    HOLD_AT_PIXEL = 170;
  localparam longint TIME_LIMIT_NS = 10_000_000;

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic [mbd_pkg::CHAN_W-1:0]       red;
  logic [mbd_pkg::CHAN_W-1:0]       green;
  logic [mbd_pkg::CHAN_W-1:0]       blue;
  logic [mbd_pkg::CHAN_W-1:0]       alpha;
  logic                             out_valid;
  logic                             out_stall;
  logic [mbd_pkg::CHAN_W-1:0]       out_red;
  logic [mbd_pkg::CHAN_W-1:0]       out_green;
  logic [mbd_pkg::CHAN_W-1:0]       out_blue;
  logic [mbd_pkg::CHAN_W-1:0]       out_alpha;
  logic                             last_pixel;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [mbd_pkg::CFG_INDEX_W-1:0]  cfg_index;
  logic [mbd_pkg::SIZE_W-1:0]       cfg_data;

  bit              no_gaps;
  bit              hold_request;
  downsample_board board;

  mipmap_box_downsample_rgba u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha),
    .last_pixel (last_pixel),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIME_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  function automatic rgba_t rgba(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    return {a, b, g, r};
  endfunction

  // Valid stays high from one request to the next unless a gap is drawn.
  task automatic push_pixel(rgba_t pix);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    red      <= pix[0];
    green    <= pix[1];
    blue     <= pix[2];
    alpha    <= pix[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_source_pixel(pix);
  endtask

  // Drain every expected pixel, then allow for pixels still in the pipe
  // that produce nothing before the sizes may change.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [mbd_pkg::CFG_INDEX_W-1:0] index,
                                logic [mbd_pkg::SIZE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_gaps && ($urandom_range(99) < 21);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_output_pixel(out_red, out_green, out_blue, out_alpha, last_pixel);
    end
  end

  initial begin
    int unsigned fed;
    int unsigned n;
    int unsigned sel;
    int unsigned w_cfg;
    int unsigned h_cfg;
    board        = new();
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    red       <= '0;
    green     <= '0;
    blue      <= '0;
    alpha     <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= mbd_pkg::REG_SRC_WIDTH;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset sizes give a 2x2 source: saturated block, then truncation.
    repeat (4) push_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_pixel(rgba(8'h00, 8'hFF, 8'd3, 8'd1));
    push_pixel(rgba(8'h00, 8'hFF, 8'd3, 8'd1));
    push_pixel(rgba(8'h00, 8'hFF, 8'd3, 8'd1));
    push_pixel(rgba(8'h00, 8'hFF, 8'd2, 8'd0));

    // Odd sizes: the trailing column and row must be dropped.
    settle();
    write_register(mbd_pkg::REG_SRC_WIDTH, 13'd3);
    write_register(mbd_pkg::REG_SRC_HEIGHT, 13'd3);
    push_pixel(rgba(8'd10, 8'd20, 8'd30, 8'd40));
    push_pixel(rgba(8'd11, 8'd21, 8'd31, 8'd41));
    push_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_pixel(rgba(8'd12, 8'd22, 8'd32, 8'd42));
    push_pixel(rgba(8'd13, 8'd23, 8'd33, 8'd43));
    repeat (4) push_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));

    // Sizes below the minimum, and a restart by a write to an unused index.
    settle();
    write_register(mbd_pkg::REG_SRC_WIDTH, 13'd1);
    write_register(mbd_pkg::REG_SRC_HEIGHT, 13'd0);
    push_pixel(rgba(8'h5A, 8'hA5, 8'h01, 8'h80));
    push_pixel(rgba(8'hFF, 8'h00, 8'h7F, 8'hFE));
    settle();
    write_register(REG_SPARE_LO, SIZE_ALL_ONES);
    repeat (4) push_pixel(rgba_t'($urandom));

    // A wide level. The long output hold comes in the odd row so the
    // request queue fills and the input stalls.
    settle();
    write_register(mbd_pkg::REG_SRC_WIDTH, BIG_SIDE);
    write_register(mbd_pkg::REG_SRC_HEIGHT, 13'd2);
    for (int i = 0; i < BIG_LEVEL; i++) begin
      if (i == HOLD_AT_PIXEL) hold_request = 1'b1;
      push_pixel(rgba_t'($urandom));
    end

    // A tall, narrow level.
    settle();
    write_register(mbd_pkg::REG_SRC_WIDTH, 13'd2);
    write_register(mbd_pkg::REG_SRC_HEIGHT, BIG_SIDE);
    repeat (BIG_LEVEL) push_pixel(rgba_t'($urandom));

    fed = 0;
    while (fed < RANDOM_ITEMS) begin
      settle();
      sel = $urandom_range(99);
      if (sel < 75) w_cfg = $urandom_range(2, 12);
      else if (sel < 85) w_cfg = $urandom_range(0, 1);
      else w_cfg = $urandom_range(13, 64);
      sel = $urandom_range(99);
      if (sel < 80) h_cfg = $urandom_range(2, 9);
      else if (sel < 88) h_cfg = $urandom_range(0, 1);
      else h_cfg = $urandom_range(10, 16);
      if ($urandom_range(1) == 0) begin
        write_register(mbd_pkg::REG_SRC_WIDTH, mbd_pkg::SIZE_W'(w_cfg));
        write_register(mbd_pkg::REG_SRC_HEIGHT, mbd_pkg::SIZE_W'(h_cfg));
      end else begin
        write_register(mbd_pkg::REG_SRC_HEIGHT, mbd_pkg::SIZE_W'(h_cfg));
        write_register(mbd_pkg::REG_SRC_WIDTH, mbd_pkg::SIZE_W'(w_cfg));
      end
      if ($urandom_range(3) == 0) write_register(REG_SPARE_HI, mbd_pkg::SIZE_W'($urandom));
      n = board.level_size();
      if (n <= 200) n = n * $urandom_range(1, 3);
      // Now and then a level is cut short; the next write restarts it.
      if ($urandom_range(4) == 0) n = n + $urandom_range(1, board.level_size() - 1);
      if (n > RANDOM_ITEMS - fed) n = RANDOM_ITEMS - fed;
      repeat (n) begin
        no_gaps = (fed >= 600 && fed < 1000);
        push_pixel(rgba_t'($urandom));
        fed++;
      end
    end
    no_gaps = 1'b0;

    settle();
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
